### design/kso_pkg.sv
`default_nettype none

package kso_pkg;

  // Request operation codes.
  localparam logic [2:0] FN_CREATE  = 3'd0;
  localparam logic [2:0] FN_DELETE  = 3'd1;
  localparam logic [2:0] FN_GET_OWN = 3'd2;
  localparam logic [2:0] FN_SET_OWN = 3'd3;
  localparam logic [2:0] FN_CHECK   = 3'd4;

  // Response status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DENIED  = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Owner bits that set_owner never takes from owner_req.
  localparam logic [31:0] OWN_KEEP_MASK = 32'd7;
  // Owner mask of a default slot after reset.
  localparam logic [31:0] OWN_DEFAULT   = 32'd7;
  localparam logic [7:0]  ROOT_RESET    = 8'd255;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  handle;
    logic [4:0]  pid;
    logic [1:0]  obj_type;
    logic [2:0]  obj_subtype;
    logic [31:0] owner_req;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  new_handle;
    logic [31:0] owner_out;
    logic [1:0]  slot_type;
    logic [2:0]  slot_subtype;
    logic        granted;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic commit;
  } cmd_t;

endpackage

`default_nettype wire

### design/kso_if.sv
`default_nettype none

interface kso_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [7:0]  handle;
  logic [4:0]  pid;
  logic [1:0]  obj_type;
  logic [2:0]  obj_subtype;
  logic [31:0] owner_req;

  modport source (output valid, func, handle, pid, obj_type, obj_subtype, owner_req,
                  input ready);
  modport sink (input valid, func, handle, pid, obj_type, obj_subtype, owner_req,
                output ready);
endinterface

interface kso_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  new_handle;
  logic [31:0] owner_out;
  logic [1:0]  slot_type;
  logic [2:0]  slot_subtype;
  logic        granted;

  modport source (output valid, status, new_handle, owner_out, slot_type, slot_subtype,
                  granted, input ready);
  modport sink (input valid, status, new_handle, owner_out, slot_type, slot_subtype,
                granted, output ready);
endinterface

interface kso_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

### design/kso_ctrl.sv
`default_nettype none

module kso_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output kso_pkg::cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   load, commit;

  assign load   = in_valid && (state_r == S_IDLE);
  // The result register must be empty or emptying before it is overwritten.
  assign commit = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (load) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign cmd.load   = load;
  assign cmd.commit = commit;

endmodule

`default_nettype wire

### design/kso_datapath.sv
`default_nettype none

module kso_datapath #(
  parameter int NUM_SLOTS   = 32,
  parameter int NUM_DEFAULT = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  kso_pkg::cmd_t cmd,
  input  kso_pkg::req_t req,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_data,
  output kso_pkg::rsp_t rsp
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int LK_N  = 1 << IDX_W;
  localparam int GRP_N = (NUM_SLOTS + 7) / 8;
  localparam int PAD_N = GRP_N * 8;
  localparam logic [8:0] SLOT_LIM = 9'(NUM_SLOTS);
  localparam logic [8:0] DEF_LIM  = 9'(NUM_DEFAULT);

  // Per-slot flags held in flip-flops.
  logic [NUM_SLOTS-1:0] in_use_r;
  logic [NUM_SLOTS-1:0] own_wr_r;
  logic [NUM_SLOTS-1:0] meta_wr_r;

  // Slot stores.
  logic [31:0] owner_mem [NUM_SLOTS];
  logic [1:0]  type_mem  [NUM_SLOTS];
  logic [2:0]  sub_mem   [NUM_SLOTS];

  kso_pkg::req_t req_r;
  logic [31:0]   rd_owner_r;
  logic [1:0]    rd_type_r;
  logic [2:0]    rd_sub_r;
  logic [7:0]    root_r;
  kso_pkg::rsp_t rsp_r, rsp_nxt;

  logic [GRP_N-1:0] grp_free, grp_free_r;
  logic [2:0]       grp_off   [GRP_N];
  logic [2:0]       grp_off_r [GRP_N];

  logic [PAD_N-1:0] use_pad;
  logic [LK_N-1:0]  use_lk, own_wr_lk, meta_wr_lk;

  for (genvar i = 0; i < PAD_N; i++) begin : g_pad
    if (i < NUM_SLOTS) begin : g_real
      assign use_pad[i] = in_use_r[i];
    end else begin : g_fill
      assign use_pad[i] = 1'b1;
    end
  end

  for (genvar i = 0; i < LK_N; i++) begin : g_lk
    if (i < NUM_SLOTS) begin : g_real
      assign use_lk[i]     = in_use_r[i];
      assign own_wr_lk[i]  = own_wr_r[i];
      assign meta_wr_lk[i] = meta_wr_r[i];
    end else begin : g_fill
      assign use_lk[i]     = 1'b0;
      assign own_wr_lk[i]  = 1'b0;
      assign meta_wr_lk[i] = 1'b0;
    end
  end

  // First level of the free-slot search: lowest free slot within each group of eight.
  always_comb begin
    for (int g = 0; g < GRP_N; g++) begin
      grp_free[g] = 1'b0;
      grp_off[g]  = 3'd0;
      for (int k = 7; k >= 0; k--) begin
        if (!use_pad[g*8 + k]) begin
          grp_free[g] = 1'b1;
          grp_off[g]  = 3'(k);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r      <= req;
      rd_owner_r <= owner_mem[req.handle[IDX_W-1:0]];
      rd_type_r  <= type_mem[req.handle[IDX_W-1:0]];
      rd_sub_r   <= sub_mem[req.handle[IDX_W-1:0]];
      grp_free_r <= grp_free;
      for (int g = 0; g < GRP_N; g++) begin
        grp_off_r[g] <= grp_off[g];
      end
    end
  end

  // Execution on the captured request.
  logic [IDX_W-1:0] hidx, free_idx;
  logic             free_found;
  logic             h_valid, h_in_use, h_default, h_root, h_owns;
  logic [31:0]      pid_bit, owner_h, merged;
  logic [1:0]       type_h;
  logic [2:0]       sub_h;
  logic             do_create, do_delete, do_set_own;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int g = GRP_N - 1; g >= 0; g--) begin
      if (grp_free_r[g]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(g*8 + int'(grp_off_r[g]));
      end
    end
  end

  assign hidx      = req_r.handle[IDX_W-1:0];
  assign h_valid   = {1'b0, req_r.handle} < SLOT_LIM;
  assign h_in_use  = h_valid && use_lk[hidx];
  assign h_root    = (req_r.handle == root_r);
  assign h_default = ({1'b0, req_r.handle} < DEF_LIM) || h_root;
  assign pid_bit   = 32'd1 << req_r.pid;
  // A store entry never written reads as its reset value.
  assign owner_h   = own_wr_lk[hidx] ? rd_owner_r :
                     (({1'b0, req_r.handle} < DEF_LIM) ? kso_pkg::OWN_DEFAULT : 32'd0);
  assign type_h    = meta_wr_lk[hidx] ? rd_type_r : 2'd0;
  assign sub_h     = meta_wr_lk[hidx] ? rd_sub_r : 3'd0;
  assign h_owns    = h_root || (h_in_use && ((owner_h & pid_bit) != 32'd0));
  assign merged    = owner_h | pid_bit;

  always_comb begin
    rsp_nxt    = '0;
    do_create  = 1'b0;
    do_delete  = 1'b0;
    do_set_own = 1'b0;
    case (req_r.func)
      kso_pkg::FN_CREATE: begin
        if (free_found) begin
          do_create          = 1'b1;
          rsp_nxt.status     = kso_pkg::ST_OK;
          rsp_nxt.new_handle = 8'(free_idx);
        end else begin
          rsp_nxt.status = kso_pkg::ST_FULL;
        end
      end
      kso_pkg::FN_DELETE: begin
        if (h_default || !h_owns) begin
          rsp_nxt.status = kso_pkg::ST_DENIED;
        end else if (!h_valid) begin
          rsp_nxt.status = kso_pkg::ST_INVALID;
        end else begin
          do_delete = 1'b1;
        end
      end
      kso_pkg::FN_GET_OWN: begin
        if (h_in_use) begin
          rsp_nxt.owner_out    = owner_h;
          rsp_nxt.slot_type    = type_h;
          rsp_nxt.slot_subtype = sub_h;
        end else begin
          rsp_nxt.status = kso_pkg::ST_INVALID;
        end
      end
      kso_pkg::FN_SET_OWN: begin
        if (!h_owns) begin
          rsp_nxt.status = kso_pkg::ST_DENIED;
        end else if (!h_valid) begin
          rsp_nxt.status = kso_pkg::ST_INVALID;
        end else if (merged != pid_bit) begin
          rsp_nxt.status = kso_pkg::ST_DENIED;
        end else begin
          do_set_own = 1'b1;
        end
      end
      kso_pkg::FN_CHECK: begin
        rsp_nxt.granted = h_owns;
      end
      default: begin
        rsp_nxt.status = kso_pkg::ST_INVALID;
      end
    endcase
  end

  // Store writes: the owner store has one write port shared by create and set_owner.
  logic             own_we, meta_we;
  logic [IDX_W-1:0] own_wa;
  logic [31:0]      own_wd;

  assign own_we  = cmd.commit && (do_create || do_set_own);
  assign own_wa  = do_create ? free_idx : hidx;
  assign own_wd  = do_create ? pid_bit :
                   ((req_r.owner_req & ~kso_pkg::OWN_KEEP_MASK) | merged);
  assign meta_we = cmd.commit && do_create;

  always_ff @(posedge clk) begin
    if (own_we) begin
      owner_mem[own_wa] <= own_wd;
    end
    if (meta_we) begin
      type_mem[free_idx] <= req_r.obj_type;
      sub_mem[free_idx]  <= req_r.obj_subtype;
    end
    if (cmd.commit) begin
      rsp_r <= rsp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        in_use_r[i] <= (i < NUM_DEFAULT);
      end
      own_wr_r  <= '0;
      meta_wr_r <= '0;
      root_r    <= kso_pkg::ROOT_RESET;
    end else begin
      if (cfg_we) begin
        root_r <= cfg_data;
      end
      if (cmd.commit && do_create) begin
        in_use_r[free_idx]  <= 1'b1;
        meta_wr_r[free_idx] <= 1'b1;
      end
      if (cmd.commit && do_delete) begin
        in_use_r[hidx] <= 1'b0;
      end
      if (own_we) begin
        own_wr_r[own_wa] <= 1'b1;
      end
    end
  end

  assign rsp = rsp_r;

endmodule

`default_nettype wire

### design/key_slot_ownership_table_unit.sv
// Key-slot ownership table: create, delete, read and change ownership of key slots,
// and check whether a process may use a handle.
// in_ch carries one request word (func, handle, pid, obj_type, obj_subtype, owner_req);
// out_ch returns exactly one response word per request, in request order; cfg_ch writes
// the root handle and is always ready, but must only be used while no request is in flight.
// An accepted request is captured with its store reads; in the execute state its response is
// registered once the output register is empty or being taken, and out_ch.valid then rises.
// A new request is taken only after the previous one is committed: the state is read and the
// free-slot search's first level is registered at acceptance, the update written at commit.
// The free-slot search runs as a two-level tree over groups of eight slots.
// Reset (rst_n low, synchronous) marks the default slots in use with owner mask 7, all other
// slots free, and sets the root handle to 255. No clearing pass is needed: per-slot written
// flags make untouched store entries read as their reset value.
// If the receiver stalls with a response pending, the next request may still be accepted,
// and its result waits in the execute cycle until the output register is taken.
`default_nettype none

module key_slot_ownership_table_unit #(
  parameter int NUM_SLOTS   = 32,
  parameter int NUM_DEFAULT = 12
) (
  input logic       clk,
  input logic       rst_n,
  kso_req_if.sink   in_ch,
  kso_rsp_if.source out_ch,
  kso_cfg_if.sink   cfg_ch
);

  kso_pkg::cmd_t cmd;
  kso_pkg::req_t req;
  kso_pkg::rsp_t rsp;

  // The root handle register can be written at any time.
  assign cfg_ch.ready = 1'b1;

  assign req.func        = in_ch.func;
  assign req.handle      = in_ch.handle;
  assign req.pid         = in_ch.pid;
  assign req.obj_type    = in_ch.obj_type;
  assign req.obj_subtype = in_ch.obj_subtype;
  assign req.owner_req   = in_ch.owner_req;

  kso_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  kso_datapath #(
    .NUM_SLOTS   (NUM_SLOTS),
    .NUM_DEFAULT (NUM_DEFAULT)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .req      (req),
    .cfg_we   (cfg_ch.valid && cfg_ch.ready),
    .cfg_data (cfg_ch.data),
    .rsp      (rsp)
  );

  assign out_ch.status       = rsp.status;
  assign out_ch.new_handle   = rsp.new_handle;
  assign out_ch.owner_out    = rsp.owner_out;
  assign out_ch.slot_type    = rsp.slot_type;
  assign out_ch.slot_subtype = rsp.slot_subtype;
  assign out_ch.granted      = rsp.granted;

  // Only one request is in flight: acceptance closes the input for the next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted while another is in flight");

  // A committed result must appear on the output in the following cycle.
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_ch.valid)
    else $error("committed response not presented");

  // Loading a new request and committing a result never coincide.
  a_load_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !cmd.commit)
    else $error("load and commit in the same cycle");

endmodule

`default_nettype wire
